[rtl/scd_pkg.sv]
// Shared types and constants for the second-chance block cache directory.
`default_nettype none
package scd_pkg;
    localparam int CAPACITY = 64;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int FILE_W = 16;
    localparam int BLOCK_W = 32;
    localparam int OUT_SLOT_W = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic               touch;     // set referenced bit of hit slot
        logic               fill;      // write new key into target slot
        logic               clear_ref; // sweep clears referenced bit of target slot
        logic               wr;        // access is a write
        logic [SLOT_W-1:0]  target;
    } cell_cmd_t;
endpackage
`default_nettype wire

[rtl/scd_cell.sv]
// One directory slot: key, flags, match and a pass-along hit chain.
`default_nettype none
module scd_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [scd_pkg::SLOT_W-1:0] my_index,
    input  wire scd_pkg::cell_cmd_t       cmd,
    input  wire logic [scd_pkg::FILE_W-1:0]  key_file,
    input  wire logic [scd_pkg::BLOCK_W-1:0] key_block,
    input  wire logic                     hit_in,
    input  wire logic [scd_pkg::SLOT_W-1:0] slot_in,
    output logic                          hit_out,
    output logic [scd_pkg::SLOT_W-1:0]    slot_out,
    output logic                          ref_bit,
    output logic                          dirty_bit,
    output logic [scd_pkg::FILE_W-1:0]    file_q,
    output logic [scd_pkg::BLOCK_W-1:0]   block_q
);
    import scd_pkg::*;

    logic valid_reg, ref_reg, dirty_reg;
    logic [FILE_W-1:0]  file_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic sel, match;

    assign sel   = (cmd.target == my_index);
    assign match = valid_reg && (file_reg == key_file) && (block_reg == key_block);

    // Lowest matching slot wins: an earlier hit passes through unchanged.
    assign hit_out  = hit_in | match;
    assign slot_out = hit_in ? slot_in : my_index;

    assign ref_bit   = ref_reg;
    assign dirty_bit = dirty_reg;
    assign file_q    = file_reg;
    assign block_q   = block_reg;

    // Flag state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ref_reg   <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else if (sel)
        begin
            if (cmd.fill)
            begin
                valid_reg <= 1'b1;
                ref_reg   <= 1'b1;
                dirty_reg <= cmd.wr;
            end
            else if (cmd.touch)
            begin
                ref_reg <= 1'b1;
                if (cmd.wr)
                    dirty_reg <= 1'b1;
            end
            else if (cmd.clear_ref)
                ref_reg <= 1'b0;
        end
    end

    // Key storage
    always_ff @(posedge clk)
    begin
        if (sel && cmd.fill)
        begin
            file_reg  <= key_file;
            block_reg <= key_block;
        end
    end
endmodule
`default_nettype wire

[rtl/second_chance_block_cache_directory.sv]
// Top level: controller, clock hand and the chain of directory cells.
// Each access is one beat in and one result beat out. An accepted access
// goes to the lookup state; a hit, or a miss while the directory is
// filling, goes from there to the done state, where out_valid is high.
// in_stall stays high until the result beat is taken, so the block takes no
// new access while one is in flight. A miss on a full directory goes to the
// sweep state, which tests the slot at the clock hand and advances it: it
// clears each referenced slot it passes and evicts the first unreferenced one.
// The match is taken combinationally through a chain of CAPACITY cells.
// After reset all slots are empty; no clearing pass is needed.
`default_nettype none
module second_chance_block_cache_directory (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] file_id,
    input  wire logic [31:0] block_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [5:0]       slot,
    output logic             evicted,
    output logic [15:0]      evicted_file,
    output logic [31:0]      evicted_block,
    output logic             writeback
);
    import scd_pkg::*;

    state_t state_reg, state_next;
    logic               wr_reg;
    logic [FILE_W-1:0]  file_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [SLOT_W-1:0]  hand_reg, hand_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               ev_reg, ev_next;
    logic [FILE_W-1:0]  evf_reg, evf_next;
    logic [BLOCK_W-1:0] evb_reg, evb_next;
    logic               wb_reg, wb_next;

    cell_cmd_t cmd;

    logic               chain_hit  [CAPACITY+1];
    logic [SLOT_W-1:0]  chain_slot [CAPACITY+1];
    logic [CAPACITY-1:0] ref_vec, dirty_vec;
    logic [FILE_W-1:0]  file_vec  [CAPACITY];
    logic [BLOCK_W-1:0] block_vec [CAPACITY];

    assign chain_hit[0]  = 1'b0;
    assign chain_slot[0] = '0;

    // Directory cells, hit chain passes slot to slot
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        scd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .my_index  (SLOT_W'(g)),
            .cmd       (cmd),
            .key_file  (file_reg),
            .key_block (block_reg),
            .hit_in    (chain_hit[g]),
            .slot_in   (chain_slot[g]),
            .hit_out   (chain_hit[g+1]),
            .slot_out  (chain_slot[g+1]),
            .ref_bit   (ref_vec[g]),
            .dirty_bit (dirty_vec[g]),
            .file_q    (file_vec[g]),
            .block_q   (block_vec[g])
        );
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign hit           = hit_reg;
    assign slot          = OUT_SLOT_W'(slot_reg);
    assign evicted       = ev_reg;
    assign evicted_file  = evf_reg;
    assign evicted_block = evb_reg;
    assign writeback     = wb_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hand_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            fill_reg  <= fill_next;
        end
    end

    // Request and result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            wr_reg    <= req_type;
            file_reg  <= file_id;
            block_reg <= block_index;
        end
        hit_reg  <= hit_next;
        slot_reg <= slot_next;
        ev_reg   <= ev_next;
        evf_reg  <= evf_next;
        evb_reg  <= evb_next;
        wb_reg   <= wb_next;
    end

    // Next state, cell commands and results
    always_comb
    begin
        state_next = state_reg;
        hand_next  = hand_reg;
        fill_next  = fill_reg;
        hit_next   = hit_reg;
        slot_next  = slot_reg;
        ev_next    = ev_reg;
        evf_next   = evf_reg;
        evb_next   = evb_reg;
        wb_next    = wb_reg;
        cmd        = '{touch: 1'b0, fill: 1'b0, clear_ref: 1'b0, wr: wr_reg,
                       target: hand_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                ev_next  = 1'b0;
                evf_next = '0;
                evb_next = '0;
                wb_next  = 1'b0;
                if (chain_hit[CAPACITY])
                begin
                    hit_next   = 1'b1;
                    slot_next  = chain_slot[CAPACITY];
                    cmd.touch  = 1'b1;
                    cmd.target = chain_slot[CAPACITY];
                    state_next = ST_DONE;
                end
                else if (fill_reg != FILL_W'(CAPACITY))
                begin
                    hit_next   = 1'b0;
                    slot_next  = fill_reg[SLOT_W-1:0];
                    cmd.fill   = 1'b1;
                    cmd.target = fill_reg[SLOT_W-1:0];
                    fill_next  = fill_reg + FILL_W'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.target = hand_reg;
                hand_next  = (hand_reg == SLOT_W'(CAPACITY - 1)) ? '0
                             : hand_reg + SLOT_W'(1);
                if (ref_vec[hand_reg])
                    cmd.clear_ref = 1'b1;
                else
                begin
                    cmd.fill   = 1'b1;
                    slot_next  = hand_reg;
                    ev_next    = 1'b1;
                    evf_next   = file_vec[hand_reg];
                    evb_next   = block_vec[hand_reg];
                    wb_next    = dirty_vec[hand_reg];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[tb/tb_second_chance_block_cache_directory.sv]
// Testbench for the second-chance block cache directory: random accesses checked by a scoreboard.
`timescale 1ns / 100ps
module tb_second_chance_block_cache_directory;
    import scd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    // Access kinds
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    typedef struct packed {
        logic         hit;
        logic [5:0]   slot;
        logic         evicted;
        logic [15:0]  evicted_file;
        logic [31:0]  evicted_block;
        logic         writeback;
    } lookup_t;

    // Directory shadow and queue of expected lookups
    class dir_scoreboard;
        bit           vld [CAPACITY];
        bit           refd [CAPACITY];
        bit           drt [CAPACITY];
        bit [15:0]    fil [CAPACITY];
        bit [31:0]    blk [CAPACITY];
        int unsigned  hand;
        int unsigned  filled;
        lookup_t      pending[$];
        int           errors;

        function void clear();
            for (int i = 0; i < CAPACITY; i++)
            begin
                vld[i] = 0; refd[i] = 0; drt[i] = 0; fil[i] = 0; blk[i] = 0;
            end
            hand = 0;
            filled = 0;
            errors = 0;
            pending.delete();
        endfunction

        // Predict the lookup caused by one accepted access
        function void note_access(logic wr, logic [15:0] f, logic [31:0] b);
            lookup_t r;
            int unsigned s;
            int unsigned h;
            bit found;
            r = '{default: '0};
            found = 0;
            s = 0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (!found && vld[i] && fil[i] == f && blk[i] == b)
                begin
                    found = 1;
                    s = i;
                end
            end
            if (found)
            begin
                refd[s] = 1;
                if (wr)
                    drt[s] = 1;
            end
            else
            begin
                if (filled < CAPACITY)
                begin
                    s = filled;
                    filled++;
                end
                else
                begin
                    h = hand;
                    for (int n = 0; n < 2 * CAPACITY && refd[h]; n++)
                    begin
                        refd[h] = 0;
                        h = (h + 1) % CAPACITY;
                    end
                    s = h;
                    r.evicted = 1;
                    r.evicted_file = fil[h];
                    r.evicted_block = blk[h];
                    r.writeback = drt[h];
                    hand = (h + 1) % CAPACITY;
                end
                vld[s] = 1; refd[s] = 1; drt[s] = wr; fil[s] = f; blk[s] = b;
            end
            r.hit = found;
            r.slot = s[5:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_lookup(lookup_t got);
            lookup_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat", $time);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got.hit !== e.hit)
                $display("%0t: hit exp %0d got %0d", $time, e.hit, got.hit);
            if (got.slot !== e.slot)
                $display("%0t: slot exp %0d got %0d", $time, e.slot, got.slot);
            if (got.evicted !== e.evicted)
                $display("%0t: evicted exp %0d got %0d", $time, e.evicted, got.evicted);
            if (got.evicted_file !== e.evicted_file)
                $display("%0t: evicted_file exp %h got %h", $time,
                         e.evicted_file, got.evicted_file);
            if (got.evicted_block !== e.evicted_block)
                $display("%0t: evicted_block exp %h got %h", $time,
                         e.evicted_block, got.evicted_block);
            if (got.writeback !== e.writeback)
                $display("%0t: writeback exp %0d got %0d", $time, e.writeback, got.writeback);
            if (got !== e)
                errors++;
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        req_type = 0;
    logic [15:0] file_id = 0;
    logic [31:0] block_index = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        hit;
    logic [5:0]  slot;
    logic        evicted;
    logic [15:0] evicted_file;
    logic [31:0] evicted_block;
    logic        writeback;

    dir_scoreboard sb;
    bit          calm = 0;       // no idling in the last part
    bit          hold_out = 0;   // long receiver hold-off
    bit          sending_done = 0;
    int          idle_cycles = 0;
    logic [15:0] hot_file [8];
    logic [31:0] hot_block [8];

    second_chance_block_cache_directory dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .file_id(file_id), .block_index(block_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .slot(slot), .evicted(evicted), .evicted_file(evicted_file),
        .evicted_block(evicted_block), .writeback(writeback)
    );

    always #5 clk = ~clk;

    // Send one access beat; valid stays up across back-to-back beats
    task automatic send_access(logic wr, logic [15:0] f, logic [31:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        req_type <= wr;
        file_id <= f;
        block_index <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_access(wr, f, b);
    endtask

    // Random access biased toward a small working set to get hits and sweeps
    task automatic send_random();
        int pick;
        logic [15:0] f;
        logic [31:0] b;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            f = 16'($urandom_range(0, 3));
            b = 32'($urandom_range(0, 79));
        end
        else if (pick < 8)
        begin
            f = hot_file[$urandom_range(0, 7)];
            b = hot_block[$urandom_range(0, 7)];
        end
        else
        begin
            f = 16'($urandom);
            b = 32'($urandom);
        end
        send_access(1'($urandom_range(0, 1)), f, b);
    endtask

    // Receiver stall: random bursts, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_out)
            out_stall <= 1;
        else if (calm)
            out_stall <= 0;
        else if (out_stall)
            out_stall <= ($urandom_range(0, 3) != 0);
        else
            out_stall <= ($urandom_range(0, 7) == 0);
    end

    // Result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_lookup('{hit, slot, evicted, evicted_file, evicted_block, writeback});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT && !hold_out)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        sb.clear();
        for (int i = 0; i < 8; i++)
        begin
            hot_file[i] = 16'($urandom);
            hot_block[i] = 32'($urandom);
        end
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: field extremes, both access kinds, hit paths
        send_access(ACC_READ, 16'h0000, 32'h0000_0000);
        send_access(ACC_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
        send_access(ACC_READ, 16'hFFFF, 32'hFFFF_FFFF);
        send_access(ACC_WRITE, 16'h0000, 32'h0000_0000);
        send_access(ACC_READ, 16'h5555, 32'hAAAA_AAAA);
        send_access(ACC_WRITE, 16'hAAAA, 32'h5555_5555);
        send_access(ACC_READ, 16'h0000, 32'hFFFF_FFFF);
        send_access(ACC_READ, 16'hFFFF, 32'h0000_0000);
        // Fill the directory up to its last slot, then hit a freshly filled slot
        for (int i = 8; i < CAPACITY; i++)
            send_access(i[0], 16'h0100, 32'(i));
        send_access(ACC_READ, 16'h0200, 32'h1);
        send_access(ACC_WRITE, 16'h0200, 32'h2);
        send_access(ACC_WRITE, 16'h0200, 32'h1);

        // Sender pauses until every expected result is back
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);

        // Long receiver hold-off while accesses keep coming
        fork
            begin
                hold_out = 1;
                repeat (300) @(posedge clk);
                hold_out = 0;
            end
            for (int i = 0; i < 40; i++)
                send_random();
        join

        for (int i = 0; i < 1400; i++)
        begin
            if (i == 1200)
                calm = 1;
            send_random();
        end
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/scd_pkg.sv
rtl/scd_cell.sv
rtl/second_chance_block_cache_directory.sv
tb/tb_second_chance_block_cache_directory.sv
